FILE: src/acfd_pkg.sv
`timescale 1ns / 1ps
package acfd_pkg;

  localparam int HEADER_BYTES   = 4;
  localparam int CHECKSUM_BYTES = 4;
  localparam int MAX_TAG_BYTES  = 8;

  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [30:0] MIN_LEN_RESET = 31'd4;
  localparam logic [30:0] MAX_LEN_RESET = 31'd67108864;

  typedef enum logic [1:0] {
    REG_TAG_WORD = 2'd0,
    REG_TAG_LEN  = 2'd1,
    REG_MIN_LEN  = 2'd2,
    REG_MAX_LEN  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_SUM,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEN   = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_BAD_TAG   = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] tag_word;
    logic [3:0]  tag_len;
    logic [30:0] min_len;
    logic [30:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [30:0] frame_length;
  } result_t;

  function automatic logic [15:0] adler_mod_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] d;
    begin
      s = {1'b0, a} + {1'b0, b};
      d = s - ADLER_MOD;
      adler_mod_add = (s >= ADLER_MOD) ? d[15:0] : s[15:0];
    end
  endfunction

endpackage

FILE: src/acfd_cfg.sv
`timescale 1ns / 1ps
module acfd_cfg
  import acfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tag_word <= '0;
      cfg.tag_len  <= '0;
      cfg.min_len  <= MIN_LEN_RESET;
      cfg.max_len  <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_TAG_WORD: cfg.tag_word <= cfg_data;
        REG_TAG_LEN:  cfg.tag_len  <= cfg_data[3:0];
        REG_MIN_LEN:  cfg.min_len  <= cfg_data[30:0];
        REG_MAX_LEN:  cfg.max_len  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/acfd_core.sv
`timescale 1ns / 1ps
module acfd_core
  import acfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [30:0] byte_count, byte_count_next;
  logic [31:0] length_reg, length_reg_next;
  logic [15:0] adler_low, adler_low_next;
  logic [15:0] adler_high, adler_high_next;
  logic [31:0] received_sum, received_sum_next;
  logic        tag_bad, tag_bad_next;

  logic [3:0]  tl;
  logic [31:0] hdr_len;
  logic [31:0] sum_word;
  logic [15:0] low_fed;
  logic [15:0] high_fed;
  logic [31:0] pos_inc;
  logic [30:0] body_end;
  logic [7:0]  want;
  logic        len_bad;

  assign tl       = (cfg.tag_len > 4'(MAX_TAG_BYTES)) ? 4'(MAX_TAG_BYTES) : cfg.tag_len;
  assign hdr_len  = {length_reg[23:0], data_byte};
  assign sum_word = {received_sum[23:0], data_byte};
  assign low_fed  = adler_mod_add(adler_low, {8'd0, data_byte});
  assign high_fed = adler_mod_add(adler_high, low_fed);
  assign pos_inc  = {1'b0, byte_count} + 32'd1;
  assign body_end = length_reg[30:0] - 31'(CHECKSUM_BYTES);
  assign want     = cfg.tag_word[8'd63 - {2'd0, byte_count[2:0], 3'd0} -: 8];
  assign len_bad  = hdr_len[31] || (hdr_len[30:0] > cfg.max_len) ||
                    (hdr_len[30:0] < cfg.min_len) ||
                    (hdr_len[30:0] < ({27'd0, tl} + 31'(CHECKSUM_BYTES)));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_count   <= '0;
      length_reg   <= '0;
      adler_low    <= 16'd1;
      adler_high   <= '0;
      received_sum <= '0;
      tag_bad      <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      length_reg   <= length_reg_next;
      adler_low    <= adler_low_next;
      adler_high   <= adler_high_next;
      received_sum <= received_sum_next;
      tag_bad      <= tag_bad_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    length_reg_next   = length_reg;
    adler_low_next    = adler_low;
    adler_high_next   = adler_high;
    received_sum_next = received_sum;
    tag_bad_next      = tag_bad;
    res_valid         = 1'b0;
    res.kind          = 1'b0;
    res.payload_byte  = '0;
    res.status        = ST_OK;
    res.frame_length  = length_reg[30:0];
    unique case (phase)
      PH_HEADER: begin
        length_reg_next = hdr_len;
        byte_count_next = pos_inc[30:0];
        if (byte_count[1:0] == 2'(HEADER_BYTES - 1)) begin
          byte_count_next = '0;
          if (len_bad) begin
            phase_next       = PH_HALT;
            res_valid        = take;
            res.kind         = 1'b1;
            res.status       = ST_BAD_LEN;
            res.frame_length = hdr_len[30:0];
          end else if (hdr_len == 32'(CHECKSUM_BYTES)) begin
            phase_next = PH_SUM;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        adler_low_next  = low_fed;
        adler_high_next = high_fed;
        if ({1'b0, byte_count} < {28'd0, tl}) begin
          if (want != data_byte) tag_bad_next = 1'b1;
        end else begin
          res_valid        = take;
          res.payload_byte = data_byte;
        end
        byte_count_next = pos_inc[30:0];
        if (pos_inc >= {1'b0, body_end}) begin
          byte_count_next = '0;
          phase_next      = PH_SUM;
        end
      end
      PH_SUM: begin
        received_sum_next = sum_word;
        byte_count_next   = pos_inc[30:0];
        if (byte_count[1:0] == 2'(CHECKSUM_BYTES - 1)) begin
          res_valid = take;
          res.kind  = 1'b1;
          if ({adler_high, adler_low} != sum_word) begin
            phase_next = PH_HALT;
            res.status = ST_BAD_SUM;
          end else if (tag_bad) begin
            phase_next = PH_HALT;
            res.status = ST_BAD_TAG;
          end else begin
            phase_next        = PH_HEADER;
            byte_count_next   = '0;
            length_reg_next   = '0;
            adler_low_next    = 16'd1;
            adler_high_next   = '0;
            received_sum_next = '0;
            tag_bad_next      = 1'b0;
          end
        end
      end
      PH_HALT: ;
      default: ;
    endcase
  end

endmodule

FILE: src/acfd_out.sv
`timescale 1ns / 1ps
module acfd_out
  import acfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t held
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && res_valid) begin
      held <= res;
    end
  end

endmodule

FILE: src/adler_checked_frame_deframer_top.sv
`timescale 1ns / 1ps
// Length-prefixed frame deframer with Adler-32 check.
// Input channel: one stream byte per request on data_byte (in_valid/in_ready).
// Each frame is a 4-byte big-endian length, the tag, the payload and a
// 4-byte big-endian Adler-32 sum over tag and payload.
// Output channel (out_valid/out_ready): kind 0 carries a payload byte,
// kind 1 carries the frame status and ends the frame; frame_length always
// reports the current frame length.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index 0 tag
// word, 1 tag length, 2 minimum length, 3 maximum length; write when idle.
// Throughput: one byte per cycle while the output is not stalled. A result
// appears on the output in the cycle after the byte that causes it is taken.
// The result register sits between the two sides; in_ready drops only while
// a result is held and the receiver stalls.
// Any length, checksum or tag error halts the block: later bytes are taken
// and dropped with no result. Reset restores the register defaults and
// starts a new frame.
module adler_checked_frame_deframer_top
  import acfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [1:0]  status,
  output logic [30:0] frame_length
);

  cfg_t    cfg;
  result_t res;
  result_t held;
  logic    res_valid;
  logic    space;

  acfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  acfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (in_valid && space),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  acfd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign in_ready     = space;
  assign kind         = held.kind;
  assign payload_byte = held.payload_byte;
  assign status       = held.status;
  assign frame_length = held.frame_length;

endmodule
